// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define PSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define PSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/pse_pkg.sv -----
// Package for the power series evaluator: widths, codes, state types, structs.
// Used by every RTL file of the block; depends on nothing.
`default_nettype none
package pse_pkg;
    localparam int FRAC_BITS = 24;
    localparam int X_W       = 32;
    localparam int MAG_W     = 63;
    localparam int SUM_W     = 64;
    localparam int M_W       = 32;
    localparam int D_W       = 28;
    localparam int P_W       = MAG_W + M_W;
    localparam int CNT_W     = 12;
    localparam int DIV_CNT_W = 7;

    localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_BITS;
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] MAX_TERMS_RST = CNT_W'(1000);

    typedef enum logic [1:0] {
        OP_EXP = 2'd0, OP_COS = 2'd1, OP_CUBIC = 2'd2, OP_DFACT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_CONV = 2'd0, ST_RANGE = 2'd1, ST_LIMIT = 2'd2, ST_OVF = 2'd3
    } t_status;

    localparam logic [1:0] CFG_EPSILON   = 2'd0;
    localparam logic [1:0] CFG_MAX_TERMS = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_COEF_D, S_COEF_M, S_START, S_WAIT, S_ADD, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        SU_IDLE, SU_MLO, SU_MHI, SU_DIV, SU_DONE
    } t_su_state;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [M_W-1:0]   m;
        logic [D_W-1:0]   d;
        logic             sh_en;
    } t_scale_req;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [MAG_W-1:0] res;
    } t_scale_rsp;
endpackage
`default_nettype wire

// ----- rtl/pse_scale_unit.sv -----
// Shared scale unit: floor(mag * m / d / 2^s) with a two-pass multiply and a
// bit-serial restoring divider. Depends on pse_pkg.
`default_nettype none
module pse_scale_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  pse_pkg::t_scale_req i_req,
    output pse_pkg::t_scale_rsp o_rsp
);
    import pse_pkg::*;

    t_su_state            r_state, n_state;
    logic [P_W-1:0]       r_q, n_q;
    logic [D_W-1:0]       r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [D_W:0]         rem_sh;
    logic [P_W-1:0]       q_sh;
    logic [63:0]          p_lo;
    logic [MAG_W-1:0]     p_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign p_lo = 64'(i_req.mag[31:0]) * 64'(i_req.m);
    assign p_hi = MAG_W'(i_req.mag[MAG_W-1:32]) * MAG_W'(i_req.m);

    always_comb begin
        n_state = r_state;
        n_q     = r_q;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        rem_sh  = {r_rem, r_q[P_W-1]};
        unique case (r_state)
            SU_IDLE: begin
                if (i_start) begin
                    n_state = SU_MLO;
                end
            end
            SU_MLO: begin
                n_q     = {{(P_W-64){1'b0}}, p_lo};
                n_state = SU_MHI;
            end
            SU_MHI: begin
                n_q   = r_q + {p_hi, 32'b0};
                n_rem = '0;
                n_cnt = DIV_CNT_W'(P_W);
                if (i_req.d == D_W'(1)) begin
                    n_state = SU_DONE;
                end else begin
                    n_state = SU_DIV;
                end
            end
            SU_DIV: begin
                if (rem_sh >= {1'b0, i_req.d}) begin
                    n_rem = D_W'(rem_sh - {1'b0, i_req.d});
                    n_q   = {r_q[P_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[D_W-1:0];
                    n_q   = {r_q[P_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    n_state = SU_DONE;
                end
            end
            SU_DONE: n_state = SU_IDLE;
            default: n_state = SU_IDLE;
        endcase
    end

    assign q_sh       = i_req.sh_en ? (r_q >> FRAC_BITS) : r_q;
    assign o_rsp.done = (r_state == SU_DONE);
    assign o_rsp.ovf  = |q_sh[P_W-1:MAG_W];
    assign o_rsp.res  = q_sh[MAG_W-1:0];
endmodule
`default_nettype wire

// ----- rtl/power_series_evaluator.sv -----
// Top level of the power series evaluator: registers, term sequencer, output
// register. Depends on pse_pkg and pse_scale_unit.
//
//  channel | handshake             | payload
//  in      | i_in_valid/o_in_stall | i_op, i_x_value
//  out     | o_out_valid/i_out_stall | o_sum_value, o_status, o_terms_used
//  cfg     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A term runs one to three passes through the shared scale unit; a pass with a
// divisor other than one also runs the one-bit-per-cycle divider.
// Reset is synchronous and needs no clearing pass; config writes are always taken.
// The input stalls while an item is in work or its result cannot be stored.
`default_nettype none
module power_series_evaluator (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire  [1:0]                  i_op,
    input  wire  signed [31:0]          i_x_value,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic signed [63:0]          o_sum_value,
    output logic [1:0]                  o_status,
    output logic [11:0]                 o_terms_used,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire  [1:0]                  i_cfg_index,
    input  wire  [31:0]                 i_cfg_data
);
    import pse_pkg::*;

    t_state           r_state, n_state;
    logic [31:0]      r_eps;
    logic [CNT_W-1:0] r_max;
    logic             r_out_valid, n_out_valid;

    t_op              r_op, n_op;
    logic [X_W-1:0]   r_xm, n_xm;
    logic             r_xneg, n_xneg;
    logic [MAG_W-1:0] r_tmag, n_tmag;
    logic             r_tneg, n_tneg, r_nneg, n_nneg;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_count, n_count, r_n, n_n;
    logic [1:0]       r_stage, n_stage;
    t_status          r_stat, n_stat;
    logic [D_W-1:0]   r_dc, n_dc, r_mc, n_mc;
    logic [SUM_W-1:0] r_o_sum, n_o_sum;
    t_status          r_o_stat, n_o_stat;
    logic [CNT_W-1:0] r_o_cnt, n_o_cnt;

    logic [X_W-1:0]   xin;
    logic [13:0]      n3, ca, cb;
    logic [1:0]       last_stage;
    logic [SUM_W-1:0] t64, sum_add;
    logic             add_ovf, tmag_le_eps, start;
    t_scale_req       req;
    t_scale_rsp       rsp;

    pse_scale_unit u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_eps       <= 32'd1;
            r_max       <= MAX_TERMS_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && i_cfg_index == CFG_EPSILON) begin
                r_eps <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == CFG_MAX_TERMS) begin
                r_max <= i_cfg_data[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_xm     <= n_xm;
        r_xneg   <= n_xneg;
        r_tmag   <= n_tmag;
        r_tneg   <= n_tneg;
        r_nneg   <= n_nneg;
        r_sum    <= n_sum;
        r_count  <= n_count;
        r_n      <= n_n;
        r_stage  <= n_stage;
        r_stat   <= n_stat;
        r_dc     <= n_dc;
        r_mc     <= n_mc;
        r_o_sum  <= n_o_sum;
        r_o_stat <= n_o_stat;
        r_o_cnt  <= n_o_cnt;
    end

    assign xin         = i_x_value[31] ? (X_W'(0) - i_x_value) : i_x_value;
    assign n3          = {2'b0, r_n} + {1'b0, r_n, 1'b0};
    assign tmag_le_eps = (r_tmag <= MAG_W'(r_eps));
    assign t64         = r_tneg ? (SUM_W'(0) - {1'b0, r_tmag}) : {1'b0, r_tmag};
    assign sum_add     = r_sum + t64;
    assign add_ovf     = (r_sum[SUM_W-1] == t64[SUM_W-1]) &&
                         (sum_add[SUM_W-1] != r_sum[SUM_W-1]);

    always_comb begin
        req.mag   = r_tmag;
        req.m     = r_xm;
        req.d     = D_W'(1);
        req.sh_en = 1'b1;
        last_stage = 2'd2;
        unique case (r_op)
            OP_EXP: begin
                req.d      = D_W'(r_n);
                last_stage = 2'd0;
            end
            OP_COS: begin
                last_stage = 2'd1;
                if (r_stage == 2'd1) begin
                    req.d = r_dc;
                end
            end
            OP_CUBIC: begin
                if (r_stage == 2'd2) begin
                    req.m     = M_W'(r_mc);
                    req.d     = r_dc;
                    req.sh_en = 1'b0;
                end
            end
            OP_DFACT: begin
                if (r_stage == 2'd2) begin
                    req.m     = M_W'({r_n, 1'b0} - 13'd1);
                    req.d     = D_W'({r_n, 1'b0});
                    req.sh_en = 1'b0;
                end
            end
            default: last_stage = 2'd2;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_op = r_op; n_xm = r_xm; n_xneg = r_xneg; n_tmag = r_tmag;
        n_tneg = r_tneg; n_nneg = r_nneg; n_sum = r_sum; n_count = r_count;
        n_n = r_n; n_stage = r_stage; n_stat = r_stat; n_dc = r_dc; n_mc = r_mc;
        n_o_sum = r_o_sum; n_o_stat = r_o_stat; n_o_cnt = r_o_cnt;
        start = 1'b0;
        ca = n3;
        cb = n3;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = t_op'(i_op);
                    n_xm    = xin;
                    n_xneg  = i_x_value[31];
                    n_tmag  = ONE_MAG;
                    n_tneg  = 1'b0;
                    n_count = '0;
                    n_stat  = ST_CONV;
                    n_sum   = (t_op'(i_op) == OP_DFACT) ? '0 : SUM_W'(ONE_MAG);
                    if (i_op[1] && MAG_W'(xin) >= ONE_MAG) begin
                        n_sum   = '0;
                        n_stat  = ST_RANGE;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_op != OP_DFACT && tmag_le_eps) begin
                    n_stat  = ST_CONV;
                    n_state = S_OUT;
                end else if (r_count >= r_max) begin
                    n_stat  = ST_LIMIT;
                    n_state = S_OUT;
                end else begin
                    n_n     = r_count + CNT_W'(1);
                    n_state = S_COEF_D;
                end
            end
            S_COEF_D: begin
                if (r_op == OP_COS) begin
                    ca = {1'b0, r_n, 1'b0};
                    cb = {1'b0, r_n, 1'b0} - 14'd1;
                end else begin
                    ca = n3 - 14'd1;
                    cb = n3 - 14'd2;
                end
                n_dc = ca * cb;
                unique case (r_op)
                    OP_EXP:   n_nneg = r_tneg ^ r_xneg;
                    OP_CUBIC: n_nneg = r_tneg;
                    default:  n_nneg = !r_tneg;
                endcase
                n_state = S_COEF_M;
            end
            S_COEF_M: begin
                n_mc    = ca * cb;
                n_stage = 2'd0;
                n_state = S_START;
            end
            S_START: begin
                start   = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (rsp.done) begin
                    if (rsp.ovf) begin
                        n_sum   = r_nneg ? SUM_MIN : SUM_MAX;
                        n_stat  = ST_OVF;
                        n_state = S_OUT;
                    end else begin
                        n_tmag = rsp.res;
                        if (r_stage == last_stage) begin
                            n_tneg  = r_nneg;
                            n_state = S_ADD;
                        end else begin
                            n_stage = r_stage + 2'd1;
                            n_state = S_START;
                        end
                    end
                end
            end
            S_ADD: begin
                if (add_ovf) begin
                    n_sum   = r_tneg ? SUM_MIN : SUM_MAX;
                    n_stat  = ST_OVF;
                    n_state = S_OUT;
                end else begin
                    n_sum   = sum_add;
                    n_count = r_count + CNT_W'(1);
                    if (r_op == OP_DFACT && tmag_le_eps) begin
                        n_stat  = ST_CONV;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_sum     = r_sum;
                    n_o_stat    = r_stat;
                    n_o_cnt     = r_count;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sum_value  = r_o_sum;
    assign o_status     = r_o_stat;
    assign o_terms_used = r_o_cnt;
    assign o_cfg_ready  = 1'b1;
endmodule
`default_nettype wire

// ----- rtl/pse_checker.sv -----
// Port-level checker for the power series evaluator, bound to the top level.
// Depends on assert_macros.svh and pse_pkg.
`default_nettype none
`include "assert_macros.svh"
module pse_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [63:0] o_sum_value,
    input wire [1:0]  o_status,
    input wire [11:0] o_terms_used
);
    import pse_pkg::*;

    `PSE_ASSERT_NXT(a_busy_after_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `PSE_ASSERT_IMP(a_range_empty, i_clk, i_rst_n, o_out_valid && o_status == ST_RANGE, o_sum_value == 64'd0 && o_terms_used == 12'd0)
    `PSE_ASSERT_IMP(a_ovf_saturated, i_clk, i_rst_n, o_out_valid && o_status == ST_OVF, o_sum_value == SUM_MAX || o_sum_value == SUM_MIN)
    `PSE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_sum_value) && $stable(o_status) && $stable(o_terms_used))
endmodule

bind power_series_evaluator pse_checker u_pse_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_sum_value  (o_sum_value),
    .o_status     (o_status),
    .o_terms_used (o_terms_used)
);
`default_nettype wire
